// ===== hdl/periodic_task_table_macros.svh =====
`ifndef PERIODIC_TASK_TABLE_MACROS_SVH
`define PERIODIC_TASK_TABLE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PTT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define PTT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/ptt_pkg.sv =====
package ptt_pkg;

  localparam int unsigned SLOT_W = 8;
  localparam int unsigned TIME_W = 32;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_STOP  = 2'd1,
    OP_TICK  = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    KIND_STARTED      = 3'd0,
    KIND_FULL         = 3'd1,
    KIND_STOPPED      = 3'd2,
    KIND_STOP_IGNORED = 3'd3,
    KIND_DUE          = 3'd4,
    KIND_NONE_DUE     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_DONE = 2'd2
  } state_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    logic              load;      // drop old token, place a new one at cell 0
    logic              step;      // advance token one cell
    logic              wr_start;  // selected cell takes a new task
    logic              wr_stop;   // selected cell goes inactive
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] now;
  } cmd_t;

endpackage

// ===== hdl/ptt_cell.sv =====
module ptt_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  ptt_pkg::cmd_t cmd,
  input  logic          wr_sel,
  input  logic          tok_in,
  output logic          tok_out,
  output logic          active_o,
  output logic          hit_o
);

  logic                       tok_r;
  logic                       active_r;
  logic [ptt_pkg::TIME_W-1:0] period_r;
  logic [ptt_pkg::TIME_W-1:0] last_r;
  logic [ptt_pkg::TIME_W-1:0] due_at;
  logic                       due;

  // Deadline wraps modulo 2^32 before the compare.
  assign due_at   = period_r + last_r;
  assign due      = active_r && (due_at <= cmd.now);
  assign hit_o    = tok_r && due;
  assign tok_out  = tok_r;
  assign active_o = active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= 1'b0;
    end else if (cmd.load || cmd.step) begin
      tok_r <= tok_in;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_sel && cmd.wr_start) begin
      active_r <= 1'b1;
      period_r <= cmd.period;
      last_r   <= '0;
    end else if (wr_sel && cmd.wr_stop) begin
      active_r <= 1'b0;
    end else if (cmd.step && hit_o) begin
      last_r <= cmd.now;
    end
  end

endmodule

// ===== hdl/periodic_task_table.sv =====
// Periodic task table. Start and stop beats are accepted while idle and their single
// result appears in the output register on the next cycle. A tick beat drops a token
// into a row of MAX_TASKS slot cells; the token walks one cell per cycle over the
// slots in use while the output side does not stall it, and each active cell whose
// deadline has been reached reports itself as due and stamps the tick time. No new beat
// is taken until the walk and its final output beat are through; a tick on an empty
// table is answered directly. Due slots come out in index order, the final one flagged
// with out_last; a tick with nothing due gives one none-due beat.
// A start beat on a full table is answered as rejected and slots are never reused.
module periodic_task_table #(
  parameter int unsigned MAX_TASKS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [31:0] in_period_ms,
  input  logic [7:0]  in_task_id,
  input  logic [31:0] in_now_ms,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_slot,
  output logic        out_last
);

  `include "periodic_task_table_macros.svh"

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);

  ptt_pkg::state_t             state_r, state_nxt;
  logic [CW-1:0]               slots_used_r, slots_used_nxt;
  logic [IW-1:0]               scan_idx_r, scan_idx_nxt;
  logic [ptt_pkg::TIME_W-1:0]  now_r, now_nxt;
  logic                        hold_valid_r, hold_valid_nxt;
  logic [IW-1:0]               hold_slot_r, hold_slot_nxt;
  logic                        out_valid_r, out_valid_nxt;
  ptt_pkg::kind_t              out_kind_r, out_kind_nxt;
  logic [ptt_pkg::SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic                        out_last_r, out_last_nxt;

  logic                        in_accept;
  logic                        out_free;
  logic                        step;
  logic                        load;
  logic                        hit;
  logic                        scan_end;
  logic                        table_full;
  logic                        stop_ok;
  logic                        wr_start;
  logic                        wr_stop;
  logic [IW-1:0]               wr_idx;
  logic [CW-1:0]               last_idx;
  ptt_pkg::cmd_t               cmd;
  logic [MAX_TASKS-1:0]        wr_sel;
  logic [MAX_TASKS-1:0]        tok_vec;
  logic [MAX_TASKS-1:0]        active_vec;
  logic [MAX_TASKS-1:0]        hit_vec;

  assign in_accept  = in_valid && in_ready;
  assign out_free   = !out_valid_r || out_ready;
  assign hit        = |hit_vec;
  assign table_full = (slots_used_r == CW'(MAX_TASKS));
  assign last_idx   = slots_used_r - 1'b1;
  assign scan_end   = (CW'(scan_idx_r) == last_idx);
  assign stop_ok    = (9'(in_task_id) < 9'(slots_used_r)) && active_vec[in_task_id[IW-1:0]];

  assign cmd.load     = load;
  assign cmd.step     = step;
  assign cmd.wr_start = wr_start;
  assign cmd.wr_stop  = wr_stop;
  assign cmd.period   = in_period_ms;
  assign cmd.now      = now_r;

  // Slot cells
  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
      logic tok_in;
      if (gi == 0) begin : g_head
        assign tok_in = load;
      end else begin : g_body
        assign tok_in = tok_vec[gi-1] && !load;
      end
      assign wr_sel[gi] = (wr_idx == IW'(gi));
      ptt_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .wr_sel   (wr_sel[gi]),
        .tok_in   (tok_in),
        .tok_out  (tok_vec[gi]),
        .active_o (active_vec[gi]),
        .hit_o    (hit_vec[gi])
      );
    end
  endgenerate

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ptt_pkg::ST_IDLE: begin
        if (load) state_nxt = ptt_pkg::ST_SCAN;
      end
      ptt_pkg::ST_SCAN: begin
        if (step && scan_end) state_nxt = ptt_pkg::ST_DONE;
      end
      ptt_pkg::ST_DONE: begin
        if (out_free) state_nxt = ptt_pkg::ST_IDLE;
      end
      default: state_nxt = ptt_pkg::ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready = 1'b0;
    step     = 1'b0;
    load     = 1'b0;
    unique case (state_r)
      ptt_pkg::ST_IDLE: begin
        in_ready = out_free;
        load     = in_valid && out_free &&
                   (in_operation == ptt_pkg::OP_TICK) && (slots_used_r != '0);
      end
      ptt_pkg::ST_SCAN: begin
        step = !hold_valid_r || out_free;
      end
      ptt_pkg::ST_DONE: begin
        step = 1'b0;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Datapath and output register
  always_comb begin
    slots_used_nxt = slots_used_r;
    scan_idx_nxt   = scan_idx_r;
    now_nxt        = now_r;
    hold_valid_nxt = hold_valid_r;
    hold_slot_nxt  = hold_slot_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_kind_nxt   = out_kind_r;
    out_slot_nxt   = out_slot_r;
    out_last_nxt   = out_last_r;
    wr_start       = 1'b0;
    wr_stop        = 1'b0;
    wr_idx         = slots_used_r[IW-1:0];

    if (in_accept) begin
      case (in_operation)
        ptt_pkg::OP_START: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (table_full) begin
            out_kind_nxt = ptt_pkg::KIND_FULL;
            out_slot_nxt = '0;
          end else begin
            out_kind_nxt   = ptt_pkg::KIND_STARTED;
            out_slot_nxt   = ptt_pkg::SLOT_W'(slots_used_r);
            wr_start       = 1'b1;
            slots_used_nxt = slots_used_r + 1'b1;
          end
        end
        ptt_pkg::OP_STOP: begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b1;
          if (stop_ok) begin
            out_kind_nxt = ptt_pkg::KIND_STOPPED;
            out_slot_nxt = in_task_id;
            wr_stop      = 1'b1;
            wr_idx       = in_task_id[IW-1:0];
          end else begin
            out_kind_nxt = ptt_pkg::KIND_STOP_IGNORED;
            out_slot_nxt = '0;
          end
        end
        ptt_pkg::OP_TICK: begin
          if (slots_used_r == '0) begin
            out_valid_nxt = 1'b1;
            out_last_nxt  = 1'b1;
            out_kind_nxt  = ptt_pkg::KIND_NONE_DUE;
            out_slot_nxt  = '0;
          end else begin
            scan_idx_nxt   = '0;
            now_nxt        = in_now_ms;
            hold_valid_nxt = 1'b0;
          end
        end
        default: ; // undefined operation: drop the beat
      endcase
    end

    // Keep one due slot in hand so the final one can carry out_last.
    if (step) begin
      scan_idx_nxt = scan_idx_r + 1'b1;
      if (hit) begin
        if (hold_valid_r) begin
          out_valid_nxt = 1'b1;
          out_last_nxt  = 1'b0;
          out_kind_nxt  = ptt_pkg::KIND_DUE;
          out_slot_nxt  = ptt_pkg::SLOT_W'(hold_slot_r);
        end
        hold_valid_nxt = 1'b1;
        hold_slot_nxt  = scan_idx_r;
      end
    end

    if ((state_r == ptt_pkg::ST_DONE) && out_free) begin
      out_valid_nxt = 1'b1;
      out_last_nxt  = 1'b1;
      if (hold_valid_r) begin
        out_kind_nxt   = ptt_pkg::KIND_DUE;
        out_slot_nxt   = ptt_pkg::SLOT_W'(hold_slot_r);
        hold_valid_nxt = 1'b0;
      end else begin
        out_kind_nxt = ptt_pkg::KIND_NONE_DUE;
        out_slot_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ptt_pkg::ST_IDLE;
      slots_used_r <= '0;
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      slots_used_r <= slots_used_nxt;
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    now_r       <= now_nxt;
    hold_slot_r <= hold_slot_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_slot  = out_slot_r;
  assign out_last  = out_last_r;

  `PTT_ASSERT_NOW(a_used_bound, 1'b1, slots_used_r <= CW'(MAX_TASKS), "slot count past table size")
  `PTT_ASSERT_NOW(a_one_token, state_r == ptt_pkg::ST_SCAN, $onehot(tok_vec), "scan token lost or duplicated")
  `PTT_ASSERT_NOW(a_idle_empty, state_r == ptt_pkg::ST_IDLE, !hold_valid_r, "due slot held while idle")
  `PTT_ASSERT_NEXT(a_flush_due, step && hit && hold_valid_r, out_valid_r && (out_kind_r == ptt_pkg::KIND_DUE) && !out_last_r, "held due slot not sent")

endmodule
